// ----- rtl/rgbrg_pkg.sv -----
`default_nettype none
package rgbrg_pkg;
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } t_in_item;

    typedef struct packed {
        logic [63:0] mask_bits;
        logic        last_word;
        logic [12:0] selected_count;
    } t_out_item;

    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_SEED_COL  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SEED_ROW  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_USED_COLS = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_USED_ROWS = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // write accepted pixel
        logic clr_step;   // clear one mark word
        logic seed_rd;    // read seed pixel
        logic seed_init;  // init mean from read data, queue seed
        logic pop_rd;     // pop queue head, read pixel and mark
        logic evaluate;   // test popped pixel, load divider
        logic div_step;   // one divider iteration
        logic mean_upd;   // add quotients to means
        logic nb_step;    // try to queue one neighbor
        logic out_rd;     // read one mask word
        logic out_load;   // load output register
    } t_cmd;

    typedef struct packed {
        logic queue_empty;
        logic clr_done;
        logic pop_skip;   // popped index outside image
        logic joined;
        logic div_done;
        logic nb_done;
        logic out_done;
    } t_status;
endpackage
`default_nettype wire

// ----- rtl/rgb_region_grow_flood_select_core.sv -----
`default_nettype none
// Seeded 4-connected region grower over an RGB image.
// Input requests carry one pixel each, column-major, on i_in_valid/o_in_ready;
// one pixel is taken per cycle while loading. The request with last_pixel set
// ends the load and starts the flood; the input stays stalled until the last
// mask word has been loaded into the output register.
// The flood first clears the mark and mask stores and reads the seed, then
// visits each queued pixel. A joined pixel also runs the bit-serial divider
// that updates the running means and has its four neighbors tested one at a
// time through the single-port mark memory. The flood ends when the queue is
// found empty.
// Results are mask words of 64 pixels on o_out_valid/i_out_ready; a stalled
// receiver simply holds the output register and the block waits. Reset
// returns to the load state with configuration at its reset values.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must write it only while idle, as the block does not enforce this.
module rgb_region_grow_flood_select_core #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire rgbrg_pkg::t_in_item  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output rgbrg_pkg::t_out_item      o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_idx,
    input  wire logic [8:0]           i_cfg_data
);
    logic [5:0] r_seed_col, r_seed_row;
    logic [8:0] r_thresh;
    logic [6:0] r_cols, r_rows;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_col <= '0;
            r_seed_row <= '0;
            r_thresh <= 9'd16;
            r_cols <= 7'd64;
            r_rows <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rgbrg_pkg::REG_SEED_COL:  r_seed_col <= i_cfg_data[5:0];
                rgbrg_pkg::REG_SEED_ROW:  r_seed_row <= i_cfg_data[5:0];
                rgbrg_pkg::REG_THRESHOLD: r_thresh <= i_cfg_data;
                rgbrg_pkg::REG_USED_COLS: r_cols <= i_cfg_data[6:0];
                rgbrg_pkg::REG_USED_ROWS: r_rows <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    rgbrg_pkg::t_cmd    cmd;
    rgbrg_pkg::t_status sts;
    logic out_free;
    assign out_free = !o_out_valid || i_out_ready;

    rgbrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_in_data.last_pixel),
        .o_in_ready (o_in_ready),
        .i_out_free (out_free),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    rgbrg_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item      (i_in_data),
        .i_seed_col  (r_seed_col),
        .i_seed_row  (r_seed_row),
        .i_thresh    (r_thresh),
        .i_cols      (r_cols),
        .i_rows      (r_rows),
        .i_out_pop   (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );
endmodule
`default_nettype wire

// ----- rtl/rgbrg_ctrl.sv -----
`default_nettype none
module rgbrg_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_last,
    output logic                   o_in_ready,
    input  wire logic              i_out_free,
    output rgbrg_pkg::t_cmd        o_cmd,
    input  wire rgbrg_pkg::t_status i_sts
);
    typedef enum logic [11:0] {
        S_LOAD  = 12'b000000000001,
        S_CLR   = 12'b000000000010,
        S_SEED  = 12'b000000000100,
        S_SINIT = 12'b000000001000,
        S_POP   = 12'b000000010000,
        S_PRD   = 12'b000000100000,
        S_EVAL  = 12'b000001000000,
        S_DIV   = 12'b000010000000,
        S_UPD   = 12'b000100000000,
        S_NB    = 12'b001000000000,
        S_ORD   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_LOAD);

    // Sequence load, clear, flood and mask output.
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last) n_state = S_CLR;
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_SEED;
            end
            S_SEED: begin
                o_cmd.seed_rd = 1'b1;
                n_state = S_SINIT;
            end
            S_SINIT: begin
                o_cmd.seed_init = 1'b1;
                n_state = S_POP;
            end
            // The queue head is fetched here; the pop follows once it is registered.
            S_POP: begin
                if (i_sts.queue_empty) n_state = S_ORD;
                else n_state = S_PRD;
            end
            S_PRD: begin
                o_cmd.pop_rd = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.evaluate = 1'b1;
                if (i_sts.pop_skip || !i_sts.joined) n_state = S_POP;
                else n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.mean_upd = 1'b1;
                n_state = S_NB;
            end
            S_NB: begin
                o_cmd.nb_step = 1'b1;
                if (i_sts.nb_done) n_state = S_POP;
            end
            S_ORD: begin
                if (i_out_free) begin
                    o_cmd.out_rd = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.out_load = 1'b1;
                n_state = i_sts.out_done ? S_LOAD : S_ORD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_LOAD;
        else r_state <= n_state;
    end
endmodule
`default_nettype wire

// ----- rtl/rgbrg_dp.sv -----
`default_nettype none
module rgbrg_dp #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rgbrg_pkg::t_cmd      i_cmd,
    output rgbrg_pkg::t_status        o_sts,
    input  wire rgbrg_pkg::t_in_item  i_item,
    input  wire logic [5:0]           i_seed_col,
    input  wire logic [5:0]           i_seed_row,
    input  wire logic [8:0]           i_thresh,
    input  wire logic [6:0]           i_cols,
    input  wire logic [6:0]           i_rows,
    input  wire logic                 i_out_pop,
    output logic                      o_out_valid,
    output rgbrg_pkg::t_out_item      o_out
);
    localparam int NPIX  = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (NPIX > 1) ? $clog2(NPIX) : 1;
    localparam int CW    = AW + 1;
    localparam int CLW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RLW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int QW    = CLW + RLW;       // queue entry: column and row
    localparam int NWORD = (NPIX + 63) / 64;
    localparam int WW    = (NWORD > 1) ? $clog2(NWORD) : 1;
    localparam int MW    = 8 + FRAC_BITS;
    localparam int DW    = MW + 1;          // signed difference
    localparam int NW    = CW + 1;          // signed-safe count width

    // Effective image size.
    logic [CLW:0] eff_cols;
    logic [RLW:0] eff_rows;
    always_comb begin
        if (i_cols == 7'd0) eff_cols = (CLW+1)'(1);
        else if (32'(i_cols) > MAX_COLUMNS) eff_cols = (CLW+1)'(MAX_COLUMNS);
        else eff_cols = (CLW+1)'(i_cols);
        if (i_rows == 7'd0) eff_rows = (RLW+1)'(1);
        else if (32'(i_rows) > MAX_ROWS) eff_rows = (RLW+1)'(MAX_ROWS);
        else eff_rows = (RLW+1)'(i_rows);
    end
    logic [CW-1:0] n_pix;
    assign n_pix = CW'(eff_cols) * CW'(eff_rows);

    // Pixel, mark and queue memories.
    logic [23:0]   pix_mem [NPIX];
    logic [1:0]    mark_mem [NPIX];
    logic [QW-1:0] q_mem [NPIX];

    logic [CW-1:0] r_load_idx;
    logic [CW-1:0] r_head, r_tail;
    logic [CW-1:0] r_clr;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_p;
    logic [CLW-1:0] r_pc;
    logic [RLW-1:0] r_pr;
    logic [23:0]   r_pix_rd;
    logic [MW-1:0] r_mr, r_mg, r_mb;
    logic signed [DW-1:0] r_dr, r_dg, r_db;
    logic [1:0]    r_nb;
    logic          r_nb_ph;
    logic          r_skip;

    // Pixel load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_load_idx <= '0;
        else if (i_cmd.load) begin
            if (r_load_idx < n_pix) r_load_idx <= r_load_idx + 1'b1;
            if (i_item.last_pixel) r_load_idx <= '0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_load_idx < n_pix)
            pix_mem[r_load_idx[AW-1:0]] <= {i_item.blue, i_item.green, i_item.red};
    end

    // Seed position.
    logic [CLW-1:0] sc;
    logic [RLW-1:0] sr;
    assign sc = (32'(i_seed_col) < 32'(eff_cols)) ? CLW'(i_seed_col) : CLW'(eff_cols - 1'b1);
    assign sr = (32'(i_seed_row) < 32'(eff_rows)) ? RLW'(i_seed_row) : RLW'(eff_rows - 1'b1);
    logic [AW-1:0] seed_idx;
    assign seed_idx = AW'(CW'(sc) * CW'(eff_rows) + CW'(sr));

    // Neighbor candidate, as pixel index and as column and row.
    logic           nb_ok;
    logic [AW-1:0]  nb_idx;
    logic [CLW-1:0] nb_c;
    logic [RLW-1:0] nb_r;
    always_comb begin
        nb_ok = 1'b0;
        nb_idx = r_p;
        nb_c = r_pc;
        nb_r = r_pr;
        case (r_nb)
            2'd0: begin
                nb_ok = (r_pr != 0);
                nb_idx = r_p - 1'b1;
                nb_r = r_pr - 1'b1;
            end
            2'd1: begin
                nb_ok = ((RLW+1)'(r_pr) + 1'b1 < eff_rows);
                nb_idx = r_p + 1'b1;
                nb_r = r_pr + 1'b1;
            end
            2'd2: begin
                nb_ok = (r_pc != 0);
                nb_idx = AW'(r_p - AW'(eff_rows));
                nb_c = r_pc - 1'b1;
            end
            default: begin
                nb_ok = ((CLW+1)'(r_pc) + 1'b1 < eff_cols);
                nb_idx = AW'(r_p + AW'(eff_rows));
                nb_c = r_pc + 1'b1;
            end
        endcase
    end

    // Difference of pixel against mean.
    logic signed [DW-1:0] dr, dg, db;
    assign dr = $signed({1'b0, r_pix_rd[7:0],   {FRAC_BITS{1'b0}}}) - $signed({1'b0, r_mr});
    assign dg = $signed({1'b0, r_pix_rd[15:8],  {FRAC_BITS{1'b0}}}) - $signed({1'b0, r_mg});
    assign db = $signed({1'b0, r_pix_rd[23:16], {FRAC_BITS{1'b0}}}) - $signed({1'b0, r_mb});
    logic [DW-1:0] ar, ag, ab;
    assign ar = dr[DW-1] ? DW'(-dr) : DW'(dr);
    assign ag = dg[DW-1] ? DW'(-dg) : DW'(dg);
    assign ab = db[DW-1] ? DW'(-db) : DW'(db);
    logic [DW-1:0] limu;
    assign limu = {i_thresh, {FRAC_BITS{1'b0}}};
    logic join_now;
    assign join_now = (ar < limu) && (ag < limu) && (ab < limu);

    // Mark memory port: a single address per cycle.
    logic [AW-1:0] mark_addr;
    logic [1:0]    r_mark_rd;
    logic          mark_we;
    logic [1:0]    mark_wd;
    always_comb begin
        mark_addr = r_p;
        mark_we = 1'b0;
        mark_wd = 2'd0;
        if (i_cmd.clr_step) begin
            mark_addr = r_clr[AW-1:0]; mark_we = 1'b1; mark_wd = 2'd0;
        end else if (i_cmd.seed_init) begin
            mark_addr = seed_idx; mark_we = 1'b1; mark_wd = 2'd1;
        end else if (i_cmd.evaluate && !r_skip) begin
            mark_addr = r_p; mark_we = 1'b1; mark_wd = join_now ? 2'd2 : 2'd3;
        end else if (i_cmd.nb_step && r_nb_ph) begin
            mark_addr = nb_idx;
            mark_we = nb_ok && (r_mark_rd == 2'd0);
            mark_wd = 2'd1;
        end else if (i_cmd.nb_step) begin
            mark_addr = nb_idx;
        end
    end
    always_ff @(posedge i_clk) begin
        if (mark_we) mark_mem[mark_addr] <= mark_wd;
        r_mark_rd <= mark_mem[mark_addr];
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.clr_step) r_clr <= (r_clr == CW'(NPIX - 1)) ? '0 : r_clr + 1'b1;
    end
    assign o_sts.clr_done = i_cmd.clr_step && (r_clr == CW'(NPIX - 1));

    // Queue and pixel reads; the queue head is registered before the pop.
    logic [QW-1:0]  q_rd;
    logic [CLW-1:0] q_c;
    logic [RLW-1:0] q_r;
    logic [CW-1:0]  q_pix_w;
    logic [AW-1:0]  q_pix;
    always_ff @(posedge i_clk) q_rd <= q_mem[r_head[AW-1:0]];
    assign q_c = q_rd[QW-1:RLW];
    assign q_r = q_rd[RLW-1:0];
    assign q_pix_w = CW'(q_c) * CW'(eff_rows) + CW'(q_r);
    assign q_pix = q_pix_w[AW-1:0];
    logic [AW-1:0] pix_addr;
    assign pix_addr = i_cmd.seed_rd ? seed_idx : q_pix;
    always_ff @(posedge i_clk) r_pix_rd <= pix_mem[pix_addr];

    // Queue writes: the seed goes to the first slot, neighbors to the tail.
    logic q_we;
    logic [QW-1:0] q_wd;
    logic [AW-1:0] q_waddr;
    assign q_we = i_cmd.seed_init || (i_cmd.nb_step && r_nb_ph && nb_ok && r_mark_rd == 2'd0);
    assign q_wd = i_cmd.seed_init ? {sc, sr} : {nb_c, nb_r};
    assign q_waddr = i_cmd.seed_init ? '0 : r_tail[AW-1:0];
    always_ff @(posedge i_clk) begin
        if (q_we) q_mem[q_waddr] <= q_wd;
    end

    // Restoring dividers on the magnitudes, one bit per cycle.
    logic [DW-1:0] r_qr, r_qg, r_qb, r_rr, r_rg, r_rb;
    logic [NW-1:0] r_remr, r_remg, r_remb;
    logic [$clog2(DW+1)-1:0] r_dcnt;
    logic [NW-1:0] tr, tg, tb;
    assign tr = {r_remr[NW-2:0], r_rr[DW-1]};
    assign tg = {r_remg[NW-2:0], r_rg[DW-1]};
    assign tb = {r_remb[NW-2:0], r_rb[DW-1]};
    assign o_sts.div_done = (r_dcnt == ($clog2(DW+1))'(DW - 1));

    logic [DW-1:0] qsr, qsg, qsb;
    assign qsr = (tr >= NW'(r_cnt)) ? {r_qr[DW-2:0], 1'b1} : {r_qr[DW-2:0], 1'b0};
    assign qsg = (tg >= NW'(r_cnt)) ? {r_qg[DW-2:0], 1'b1} : {r_qg[DW-2:0], 1'b0};
    assign qsb = (tb >= NW'(r_cnt)) ? {r_qb[DW-2:0], 1'b1} : {r_qb[DW-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.evaluate) begin
            r_dr <= dr; r_dg <= dg; r_db <= db;
            r_rr <= ar; r_rg <= ag; r_rb <= ab;
            r_remr <= '0; r_remg <= '0; r_remb <= '0;
            r_qr <= '0; r_qg <= '0; r_qb <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rr <= r_rr << 1; r_rg <= r_rg << 1; r_rb <= r_rb << 1;
            r_remr <= (tr >= NW'(r_cnt)) ? tr - NW'(r_cnt) : tr;
            r_remg <= (tg >= NW'(r_cnt)) ? tg - NW'(r_cnt) : tg;
            r_remb <= (tb >= NW'(r_cnt)) ? tb - NW'(r_cnt) : tb;
            r_qr <= qsr; r_qg <= qsg; r_qb <= qsb;
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    // Flood control registers and means.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0; r_tail <= '0; r_cnt <= '0;
            r_mr <= '0; r_mg <= '0; r_mb <= '0;
            r_nb <= '0; r_nb_ph <= 1'b0; r_skip <= 1'b0;
            r_p <= '0; r_pc <= '0; r_pr <= '0;
        end else begin
            if (i_cmd.seed_init) begin
                r_mr <= {r_pix_rd[7:0],   {FRAC_BITS{1'b0}}};
                r_mg <= {r_pix_rd[15:8],  {FRAC_BITS{1'b0}}};
                r_mb <= {r_pix_rd[23:16], {FRAC_BITS{1'b0}}};
                r_cnt <= '0;
                r_head <= '0;
                r_tail <= CW'(1);
            end
            if (i_cmd.pop_rd) begin
                r_p <= q_pix;
                r_pc <= q_c;
                r_pr <= q_r;
                r_skip <= (q_pix_w >= n_pix);
                r_head <= r_head + 1'b1;
            end
            if (i_cmd.evaluate) begin
                if (join_now && !r_skip) r_cnt <= r_cnt + 1'b1;
                r_nb <= '0; r_nb_ph <= 1'b0;
            end
            if (i_cmd.mean_upd) begin
                r_mr <= MW'($signed({1'b0, r_mr}) + (r_dr[DW-1] ? -$signed(r_qr) : $signed(r_qr)));
                r_mg <= MW'($signed({1'b0, r_mg}) + (r_dg[DW-1] ? -$signed(r_qg) : $signed(r_qg)));
                r_mb <= MW'($signed({1'b0, r_mb}) + (r_db[DW-1] ? -$signed(r_qb) : $signed(r_qb)));
            end
            if (i_cmd.nb_step) begin
                r_nb_ph <= !r_nb_ph;
                if (r_nb_ph) r_nb <= r_nb + 1'b1;
                if (q_we && !i_cmd.seed_init) r_tail <= r_tail + 1'b1;
            end
        end
    end
    assign o_sts.nb_done = i_cmd.nb_step && r_nb_ph && (r_nb == 2'd3);
    assign o_sts.queue_empty = (r_head == r_tail);
    assign o_sts.pop_skip = r_skip;
    assign o_sts.joined = join_now;

    // Mask output: a packed selection bitmap is kept beside the marks so that
    // a whole word can be read at once.
    logic [63:0] sel_mem [NWORD];
    logic [WW-1:0] r_ow;
    logic [63:0]  r_sel_rd, r_sel_old;
    logic [63:0]  sel_wd;
    logic [WW-1:0] sel_waddr;
    logic         sel_we;
    logic [AW-1:0] sel_pix;
    assign sel_pix = i_cmd.clr_step ? r_clr[AW-1:0] : r_p;
    assign sel_waddr = WW'(sel_pix >> 6);
    always_comb begin
        sel_wd = r_sel_old;
        sel_wd[sel_pix[5:0]] = i_cmd.evaluate && join_now;
        sel_we = (i_cmd.clr_step && r_clr[5:0] == 6'd0) ||
                 (i_cmd.evaluate && !r_skip && join_now);
        if (i_cmd.clr_step) sel_wd = '0;
    end
    // Old word is fetched while the pixel is read.
    always_ff @(posedge i_clk) begin
        r_sel_old <= sel_mem[WW'(q_pix >> 6)];
        if (sel_we) sel_mem[sel_waddr] <= sel_wd;
        r_sel_rd <= sel_mem[r_ow];
    end

    logic [CW-1:0] nwords;
    assign nwords = (n_pix + CW'(63)) >> 6;
    logic [63:0] valid_mask;
    logic [CW-1:0] wbase;
    assign wbase = CW'(r_ow) << 6;
    always_comb begin
        for (int k = 0; k < 64; k++) valid_mask[k] = (wbase + CW'(k)) < n_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ow <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_out_pop) o_out_valid <= 1'b0;
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
                o_out.mask_bits <= r_sel_rd & valid_mask;
                o_out.last_word <= (CW'(r_ow) + 1'b1 == nwords);
                o_out.selected_count <= 13'(r_cnt);
                r_ow <= (CW'(r_ow) + 1'b1 == nwords) ? '0 : r_ow + 1'b1;
            end
        end
    end
    assign o_sts.out_done = (CW'(r_ow) + 1'b1 == nwords);
endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    localparam int PIX_MAX = 4096;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int RANDOM_ITEMS = 456;

    // Directed stimulus kinds.
    typedef enum int { PAT_FLAT, PAT_RANDOM, PAT_EXTRA, PAT_EARLY } t_pattern;
    typedef enum int { CHK_GROW, CHK_ALL, CHK_NONE } t_check;

    typedef struct {
        int       cols;
        int       rows;
        int       seed_c;
        int       seed_r;
        int       thr;
        t_pattern pat;
        logic [23:0] color;
        t_check   chk;
    } t_image_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    rgbrg_pkg::t_in_item   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    rgbrg_pkg::t_out_item  o_out_data;
    logic                  i_cfg_we;
    logic [2:0]            i_cfg_idx;
    logic [8:0]            i_cfg_data;

    rgb_region_grow_flood_select_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the block state.
    logic [7:0]  img_red   [PIX_MAX];
    logic [7:0]  img_green [PIX_MAX];
    logic [7:0]  img_blue  [PIX_MAX];
    bit          img_written [PIX_MAX];
    int          load_pos;
    int          cfg_seed_c;
    int          cfg_seed_r;
    int          cfg_thr;
    int          cfg_cols;
    int          cfg_rows;

    rgbrg_pkg::t_out_item mask_expect_q[$];
    int          error_count;
    int          cycle_count;
    bit          calm;
    bit          rx_block;
    int          rx_gap;
    event        start_hold;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** rgb_region_grow_flood_select_core: FAILED **");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Grows the region from the seed and queues the mask words it yields.
    task automatic grow_region(input t_check chk);
        int        n;
        int        sc;
        int        sr;
        int        p;
        int        c;
        int        r;
        int        head;
        int        tail;
        int        words;
        int        joined;
        longint    lim;
        longint    m_r;
        longint    m_g;
        longint    m_b;
        longint    d_r;
        longint    d_g;
        longint    d_b;
        byte       mark [PIX_MAX];
        int        visit [PIX_MAX];
        int        nb [4];
        bit        ok [4];
        rgbrg_pkg::t_out_item item;
        n = cfg_cols * cfg_rows;
        sc = (cfg_seed_c < cfg_cols) ? cfg_seed_c : cfg_cols - 1;
        sr = (cfg_seed_r < cfg_rows) ? cfg_seed_r : cfg_rows - 1;
        lim = longint'(cfg_thr) <<< 16;
        foreach (mark[i]) mark[i] = 0;
        p = sc * cfg_rows + sr;
        m_r = longint'(img_red[p]) <<< 16;
        m_g = longint'(img_green[p]) <<< 16;
        m_b = longint'(img_blue[p]) <<< 16;
        joined = 0;
        head = 0;
        tail = 1;
        visit[0] = p;
        mark[p] = 1;
        while (head < tail) begin
            p = visit[head];
            head++;
            c = p / cfg_rows;
            r = p % cfg_rows;
            d_r = (longint'(img_red[p]) <<< 16) - m_r;
            d_g = (longint'(img_green[p]) <<< 16) - m_g;
            d_b = (longint'(img_blue[p]) <<< 16) - m_b;
            if ((d_r < 0 ? -d_r : d_r) < lim && (d_g < 0 ? -d_g : d_g) < lim &&
                (d_b < 0 ? -d_b : d_b) < lim) begin
                mark[p] = 2;
                joined++;
                m_r += d_r / longint'(joined);
                m_g += d_g / longint'(joined);
                m_b += d_b / longint'(joined);
                // Neighbors are tried up, down, left, right.
                nb[0] = p - 1;        ok[0] = (r > 0);
                nb[1] = p + 1;        ok[1] = (r + 1 < cfg_rows);
                nb[2] = p - cfg_rows; ok[2] = (c > 0);
                nb[3] = p + cfg_rows; ok[3] = (c + 1 < cfg_cols);
                for (int k = 0; k < 4; k++) begin
                    if (ok[k] && mark[nb[k]] == 0) begin
                        mark[nb[k]] = 1;
                        visit[tail] = nb[k];
                        tail++;
                    end
                end
            end else begin
                mark[p] = 3;
            end
        end
        words = (n + 63) / 64;
        for (int w = 0; w < words; w++) begin
            item.mask_bits = '0;
            for (int k = 0; k < 64; k++) begin
                p = w * 64 + k;
                if (p < n) begin
                    if (chk == CHK_ALL)
                        item.mask_bits[k] = 1'b1;
                    else if (chk == CHK_GROW)
                        item.mask_bits[k] = (mark[p] == 2);
                end
            end
            item.last_word = (w + 1 == words);
            item.selected_count = (chk == CHK_ALL) ? 13'(n) :
                                  (chk == CHK_NONE) ? 13'd0 : 13'(joined);
            mask_expect_q.insert(mask_expect_q.size(), item);
        end
    endtask

    // Tracks one accepted pixel request.
    task automatic pixel_accept(input rgbrg_pkg::t_in_item it, input t_check chk);
        if (load_pos < cfg_cols * cfg_rows) begin
            img_red[load_pos] = it.red;
            img_green[load_pos] = it.green;
            img_blue[load_pos] = it.blue;
            img_written[load_pos] = 1'b1;
            load_pos++;
        end
        if (it.last_pixel) begin
            grow_region(chk);
            load_pos = 0;
        end
    endtask

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_pixel(input rgbrg_pkg::t_in_item it, input t_check chk);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data = it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pixel_accept(it, chk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input int value);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = 9'(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Waits until every mask word has arrived.
    task automatic drain;
        i_in_valid = 1'b0;
        while (mask_expect_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_image(input int cols, input int rows, input int sc,
                             input int sr, input int thr);
        drain();
        cfg_write(rgbrg_pkg::REG_SEED_COL, sc);
        cfg_write(rgbrg_pkg::REG_SEED_ROW, sr);
        cfg_write(rgbrg_pkg::REG_THRESHOLD, thr);
        cfg_write(rgbrg_pkg::REG_USED_COLS, cols);
        cfg_write(rgbrg_pkg::REG_USED_ROWS, rows);
        cfg_seed_c = sc;
        cfg_seed_r = sr;
        cfg_thr = thr;
        cfg_cols = cols;
        cfg_rows = rows;
    endtask

    function automatic bit store_ready(input int n);
        for (int i = 0; i < n; i++)
            if (!img_written[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] near(input logic [7:0] base, input int spread);
        int v;
        v = int'(base) + $urandom_range(0, 2 * spread) - spread;
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
    endfunction

    // Result checking.
    always @(posedge i_clk) begin
        rgbrg_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (mask_expect_q.size() == 0) begin
                report($sformatf("unexpected mask word %h", o_out_data.mask_bits));
            end else begin
                want = mask_expect_q[0];
                mask_expect_q.delete(0);
                if (o_out_data.mask_bits !== want.mask_bits)
                    report($sformatf("mask_bits %h, want %h",
                                     o_out_data.mask_bits, want.mask_bits));
                if (o_out_data.last_word !== want.last_word)
                    report($sformatf("last_word %b, want %b",
                                     o_out_data.last_word, want.last_word));
                if (o_out_data.selected_count !== want.selected_count)
                    report($sformatf("selected_count %0d, want %0d",
                                     o_out_data.selected_count, want.selected_count));
            end
        end
        if (o_out_valid && i_out_ready)
            rx_gap <= calm ? 0 : $urandom_range(0, 4);
        else if (rx_gap > 0)
            rx_gap <= rx_gap - 1;
    end

    // Receiver ready, changed on the falling edge.
    always @(negedge i_clk) begin
        i_out_ready <= !rx_block && (rx_gap == 0);
    end

    // Long receiver hold-off, counted here; it outlasts a whole flood so the
    // next image finds the block stalled.
    initial begin
        rx_block = 1'b0;
        forever begin
            @(start_hold);
            rx_block = 1'b1;
            repeat (12000) @(posedge i_clk);
            rx_block = 1'b0;
        end
    end

    // Stimulus.
    initial begin
        t_image_row rows_tbl [7];
        t_image_row row;
        rgbrg_pkg::t_in_item it;
        int         n;
        int         cnt;
        int         items;
        int         phase;
        int         split;
        logic [23:0] col_a;
        logic [23:0] col_b;
        int         noise;
        bit         early;
        bit         wild;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = rgbrg_pkg::REG_SEED_COL;
        i_cfg_data = '0;
        i_out_ready = 1'b0;
        rx_gap = 0;
        calm = 1'b0;
        error_count = 0;
        load_pos = 0;
        foreach (img_written[i]) img_written[i] = 1'b0;
        cfg_seed_c = 0;
        cfg_seed_r = 0;
        cfg_thr = 16;
        cfg_cols = 64;
        cfg_rows = 64;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed images: sizes, extremes of threshold and seed, odd loads.
        rows_tbl[0] = '{1, 1, 0, 0, 0, PAT_FLAT, 24'hFFFFFF, CHK_NONE};
        rows_tbl[1] = '{1, 1, 63, 63, 256, PAT_FLAT, 24'h000000, CHK_ALL};
        rows_tbl[2] = '{2, 2, 1, 1, 1, PAT_FLAT, 24'hAA55AA, CHK_ALL};
        rows_tbl[3] = '{3, 2, 0, 0, 16, PAT_RANDOM, 24'h000000, CHK_GROW};
        rows_tbl[4] = '{2, 2, 0, 1, 5, PAT_EXTRA, 24'h123456, CHK_ALL};
        rows_tbl[5] = '{2, 2, 1, 0, 200, PAT_EARLY, 24'h000000, CHK_GROW};
        rows_tbl[6] = '{2, 3, 40, 2, 256, PAT_RANDOM, 24'h000000, CHK_ALL};
        foreach (rows_tbl[i]) begin
            row = rows_tbl[i];
            set_image(row.cols, row.rows, row.seed_c, row.seed_r, row.thr);
            n = row.cols * row.rows;
            cnt = (row.pat == PAT_EXTRA) ? n + 2 : (row.pat == PAT_EARLY) ? 2 : n;
            for (int k = 0; k < cnt; k++) begin
                if (row.pat == PAT_RANDOM || row.pat == PAT_EARLY)
                    {it.blue, it.green, it.red} = 24'($urandom);
                else
                    {it.blue, it.green, it.red} = row.color;
                it.last_pixel = (k == cnt - 1);
                send_pixel(it, row.chk);
            end
        end

        // Random images: mostly two-color scenes with noise. The image right
        // after a hold keeps its settings and is sent without waiting.
        items = 0;
        phase = 0;
        while (items < RANDOM_ITEMS) begin
            if (!(phase == 4 || phase == 21)) begin
                case ($urandom_range(0, 19))
                    0: set_image(64, 1, $urandom_range(0, 63), $urandom_range(0, 63), 40);
                    1: set_image(1, 64, $urandom_range(0, 63), $urandom_range(0, 63), 40);
                    2: set_image($urandom_range(8, 12), $urandom_range(8, 12),
                                 $urandom_range(0, 63), $urandom_range(0, 63),
                                 $urandom_range(0, 256));
                    default: set_image($urandom_range(1, 6), $urandom_range(1, 6),
                                       $urandom_range(0, 63), $urandom_range(0, 63),
                                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 256)
                                                                   : $urandom_range(4, 64));
                endcase
            end
            calm = ($urandom_range(0, 4) == 0);
            if (phase == 3 || phase == 20) ->start_hold;
            n = cfg_cols * cfg_rows;
            wild = ($urandom_range(0, 9) == 0);
            early = ($urandom_range(0, 19) == 0) && n > 1 && store_ready(n);
            cnt = early ? $urandom_range(1, n - 1) :
                  ($urandom_range(0, 9) == 0) ? n + $urandom_range(1, 3) : n;
            col_a = 24'($urandom);
            col_b = 24'($urandom);
            split = $urandom_range(0, n);
            noise = $urandom_range(0, 12);
            for (int k = 0; k < cnt; k++) begin
                if (wild) begin
                    {it.blue, it.green, it.red} = 24'($urandom);
                end else if (k < split) begin
                    it.red = near(col_a[7:0], noise);
                    it.green = near(col_a[15:8], noise);
                    it.blue = near(col_a[23:16], noise);
                end else begin
                    it.red = near(col_b[7:0], noise);
                    it.green = near(col_b[15:8], noise);
                    it.blue = near(col_b[23:16], noise);
                end
                it.last_pixel = (k == cnt - 1);
                send_pixel(it, CHK_GROW);
            end
            items += cnt;
            phase++;
        end

        // Wind down.
        calm = 1'b0;
        drain();
        repeat (200) @(negedge i_clk);
        if (error_count == 0) begin
            $display("** rgb_region_grow_flood_select_core: PASSED **");
        end else begin
            $display("** rgb_region_grow_flood_select_core: FAILED **");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/rgbrg_pkg.sv
rtl/rgbrg_ctrl.sv
rtl/rgbrg_dp.sv
rtl/rgb_region_grow_flood_select_core.sv
test/testbench.sv
